[src/uer_pkg.sv]
// Package with the phase type, register indexes and reset values of the echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_PRE_LOW   = 5'b00010,
		PH_PULSE     = 5'b00100,
		PH_WAIT_RISE = 5'b01000,
		PH_WAIT_FALL = 5'b10000
	} phase_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE    = 2'd3;

	localparam logic [15:0] PRE_LOW_RST = 16'd40;
	localparam logic [15:0] PULSE_RST   = 16'd20;
	localparam logic [23:0] TIMEOUT_RST = 24'd1000000;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_TIMEOUT = 1'b1;

endpackage

[src/ultrasonic_echo_ranger.sv]
// Ultrasonic echo ranger: trigger sequencer, echo width counter and distance output.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Payload
//  in        request    in_valid / in_stall     start_req, echo
//  out       result     out_valid / out_stall   trigger, busy_res, done_res, status, distance_cm
//  cfg       write      cfg_we                  cfg_index, cfg_data
//
//  One tick request is taken per clock unless stalled; its result appears in the output
//  register on the next cycle. The whole step is one pass between state and output registers.
//  The distance quotient is kept as a running quotient and remainder beside the echo counter.
//  Reset clears the sequencer and loads the register defaults; no clearing pass is needed.
//  A stalled result holds the output register and stalls the input only while it waits.

module ultrasonic_echo_ranger
	import uer_pkg::*;
#(
	parameter int unsigned CM_DIVISOR    = 58,
	parameter int unsigned TIMEOUT_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  start_req,
	input  logic                  echo,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  trigger,
	output logic                  busy_res,
	output logic                  done_res,
	output logic                  status,
	output logic [15:0]           distance_cm,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned LW = (TIMEOUT_WIDTH < 24) ? TIMEOUT_WIDTH : 24;
	localparam int unsigned CW = (LW > 16) ? LW : 16;
	localparam int unsigned RW = (CM_DIVISOR > 1) ? $clog2(CM_DIVISOR) : 1;
	localparam logic [RW-1:0] REM_LAST = RW'(CM_DIVISOR - 1);
	localparam logic [31:0] QUO_ONE = (CM_DIVISOR == 1) ? 32'd1 : 32'd0;
	localparam logic [RW-1:0] REM_ONE = (CM_DIVISOR == 1) ? RW'(0) : RW'(1);

	logic [15:0]   pre_low_q;
	logic [15:0]   pulse_q;
	logic [23:0]   timeout_q;
	logic          wide_q;

	phase_t        phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [31:0]   high_q, high_d;
	logic [31:0]   quo_q, quo_d;
	logic [RW-1:0] rem_q, rem_d;
	logic          echo_prev_q;
	logic [15:0]   last_dist_q, last_dist_d;
	logic          last_status_q, last_status_d;
	logic          trig_d, done_d;

	logic [LW-1:0] lim_raw;
	logic [CW-1:0] lim;
	logic          accept;
	logic          high_wrap;

	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// A zero timeout behaves as one.
	assign lim_raw = timeout_q[LW-1:0];
	assign lim = (lim_raw == '0) ? CW'(1) : CW'(lim_raw);

	assign high_wrap = wide_q ? (&high_q) : (&high_q[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_low_q <= PRE_LOW_RST;
			pulse_q   <= PULSE_RST;
			timeout_q <= TIMEOUT_RST;
			wide_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRE_LOW: pre_low_q <= cfg_data[15:0];
				REG_PULSE:   pulse_q   <= cfg_data[15:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_WIDE:    wide_q    <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// One tick of the sequencer; phases fall through within the same tick.
	always_comb begin
		phase_d       = phase_q;
		cnt_d         = cnt_q;
		high_d        = high_q;
		quo_d         = quo_q;
		rem_d         = rem_q;
		last_dist_d   = last_dist_q;
		last_status_d = last_status_q;
		trig_d        = 1'b0;
		done_d        = 1'b0;

		if (phase_d == PH_IDLE && start_req) begin
			phase_d = PH_PRE_LOW;
			cnt_d   = '0;
			high_d  = '0;
			quo_d   = '0;
			rem_d   = '0;
		end
		if (phase_d == PH_PRE_LOW) begin
			if (cnt_d >= CW'(pre_low_q)) begin
				phase_d = PH_PULSE;
				cnt_d   = '0;
			end else begin
				cnt_d = cnt_d + CW'(1);
			end
		end
		if (phase_d == PH_PULSE) begin
			if (cnt_d >= CW'(pulse_q)) begin
				phase_d = PH_WAIT_RISE;
				cnt_d   = '0;
			end else begin
				trig_d = 1'b1;
				cnt_d  = cnt_d + CW'(1);
			end
		end
		if (phase_d == PH_WAIT_RISE) begin
			if (echo && !echo_prev_q) begin
				phase_d = PH_WAIT_FALL;
				cnt_d   = '0;
				high_d  = 32'd1;
				quo_d   = QUO_ONE;
				rem_d   = REM_ONE;
			end else begin
				cnt_d = cnt_d + CW'(1);
				if (cnt_d >= lim) begin
					phase_d       = PH_IDLE;
					cnt_d         = '0;
					last_status_d = STATUS_TIMEOUT;
					done_d        = 1'b1;
				end
			end
		end else if (phase_d == PH_WAIT_FALL) begin
			if (!echo && echo_prev_q) begin
				last_dist_d   = (quo_q[31:16] != 16'd0) ? 16'hFFFF : quo_q[15:0];
				phase_d       = PH_IDLE;
				cnt_d         = '0;
				last_status_d = STATUS_OK;
				done_d        = 1'b1;
			end else begin
				if (echo) begin
					// Quotient and remainder follow the count, and restart when it wraps.
					if (high_wrap) begin
						high_d = '0;
						quo_d  = '0;
						rem_d  = '0;
					end else begin
						high_d = high_q + 32'd1;
						if (rem_q == REM_LAST) begin
							rem_d = '0;
							quo_d = quo_q + 32'd1;
						end else begin
							rem_d = rem_q + RW'(1);
						end
					end
				end
				cnt_d = cnt_d + CW'(1);
				if (cnt_d >= lim) begin
					phase_d       = PH_IDLE;
					cnt_d         = '0;
					last_status_d = STATUS_TIMEOUT;
					done_d        = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			cnt_q         <= '0;
			high_q        <= '0;
			quo_q         <= '0;
			rem_q         <= '0;
			echo_prev_q   <= 1'b0;
			last_dist_q   <= '0;
			last_status_q <= STATUS_OK;
		end else if (accept) begin
			phase_q       <= phase_d;
			cnt_q         <= cnt_d;
			high_q        <= high_d;
			quo_q         <= quo_d;
			rem_q         <= rem_d;
			echo_prev_q   <= echo;
			last_dist_q   <= last_dist_d;
			last_status_q <= last_status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trigger  <= trig_d;
			busy_res <= (phase_d != PH_IDLE);
			done_res <= done_d;
		end
	end

	// Distance and status are the stored last values, loaded on the same request.
	assign distance_cm = last_dist_q;
	assign status      = last_status_q;

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !busy_res)
		else $error("finishing tick still reports busy");

	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && trigger) |-> busy_res)
		else $error("trigger high outside a measurement");

	a_dist_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		(last_dist_q != $past(last_dist_q)) |-> (out_valid && done_res && status == STATUS_OK))
		else $error("distance changed without a successful finish");

	a_idle_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (cnt_q == '0))
		else $error("phase counter not cleared in idle");
`endif

endmodule

[tb/echo_ranger_checker.sv]
// Checker for the echo ranger: predicts every tick result and compares it with the block.
`timescale 1ns / 1ps

module echo_ranger_checker
	import uer_pkg::*;
#(
	parameter int unsigned CM_DIVISOR = 58,
	parameter int unsigned REPORT_CAP = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  start_req,
	input  logic                  echo,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  trigger,
	input  logic                  busy_res,
	input  logic                  done_res,
	input  logic                  status,
	input  logic [15:0]           distance_cm,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    bad_count,
	output int                    pending,
	output int                    ok_count,
	output int                    timeout_count
);

	typedef struct packed {
		logic        trig;
		logic        busy;
		logic        done;
		logic        stat;
		logic [15:0] range_cm;
	} reading_t;

	// Register copies as last written through the configuration port.
	logic [15:0] pre_len;
	logic [15:0] pulse_len;
	logic [23:0] wait_limit;
	logic        wide_count;

	// Sequencer state of the prediction.
	phase_t      ph;
	logic [31:0] ph_cnt;
	logic [31:0] echo_cnt;
	logic        echo_last;
	logic [15:0] dist_held;
	logic        stat_held;

	reading_t    readings_q[$];
	reading_t    exp_r;
	int          seen;

	// Only the first few mismatches are printed, all of them are counted.
	task automatic report_mismatch(input string msg);
		if (bad_count < REPORT_CAP)
			$display("%0t ns: result %0d: %s", $time, seen, msg);
		bad_count++;
	endtask

	function automatic reading_t ranger_tick(input logic want_start, input logic echo_level);
		reading_t    r;
		logic        fin;
		logic        fin_stat;
		logic [31:0] lim;
		logic [31:0] quot;
		r        = '0;
		fin      = 1'b0;
		fin_stat = STATUS_OK;
		// A zero timeout behaves as a timeout of one tick.
		lim = (wait_limit == '0) ? 32'd1 : {8'd0, wait_limit};

		if (ph == PH_IDLE && want_start) begin
			ph       = PH_PRE_LOW;
			ph_cnt   = '0;
			echo_cnt = '0;
		end
		if (ph == PH_PRE_LOW) begin
			if (ph_cnt >= {16'd0, pre_len}) begin
				ph     = PH_PULSE;
				ph_cnt = '0;
			end else
				ph_cnt++;
		end
		if (ph == PH_PULSE) begin
			if (ph_cnt >= {16'd0, pulse_len}) begin
				ph     = PH_WAIT_RISE;
				ph_cnt = '0;
			end else begin
				r.trig = 1'b1;
				ph_cnt++;
			end
		end
		if (ph == PH_WAIT_RISE) begin
			if (echo_level && !echo_last) begin
				ph       = PH_WAIT_FALL;
				ph_cnt   = '0;
				echo_cnt = 32'd1;
			end else begin
				ph_cnt++;
				if (ph_cnt >= lim) begin
					fin      = 1'b1;
					fin_stat = STATUS_TIMEOUT;
				end
			end
		end else if (ph == PH_WAIT_FALL) begin
			if (!echo_level && echo_last) begin
				quot      = echo_cnt / CM_DIVISOR;
				dist_held = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
				fin       = 1'b1;
				fin_stat  = STATUS_OK;
			end else begin
				if (echo_level) begin
					echo_cnt = echo_cnt + 32'd1;
					if (!wide_count)
						echo_cnt[31:16] = '0;
				end
				ph_cnt++;
				if (ph_cnt >= lim) begin
					fin      = 1'b1;
					fin_stat = STATUS_TIMEOUT;
				end
			end
		end
		if (fin) begin
			ph        = PH_IDLE;
			ph_cnt    = '0;
			stat_held = fin_stat;
		end
		echo_last = echo_level;

		r.busy     = (ph != PH_IDLE);
		r.done     = fin;
		r.stat     = stat_held;
		r.range_cm = dist_held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_len       = PRE_LOW_RST;
			pulse_len     = PULSE_RST;
			wait_limit    = TIMEOUT_RST;
			wide_count    = 1'b0;
			ph            = PH_IDLE;
			ph_cnt        = '0;
			echo_cnt      = '0;
			echo_last     = 1'b0;
			dist_held     = '0;
			stat_held     = STATUS_OK;
			readings_q.delete();
			seen          = 0;
			bad_count     = 0;
			ok_count      = 0;
			timeout_count = 0;
			pending       = 0;
		end else begin
			// A result taken on this edge belongs to an earlier request, so it is checked first.
			if (out_valid && !out_stall) begin
				if (readings_q.size() == 0)
					report_mismatch("result with no tick request outstanding");
				else begin
					exp_r = readings_q.pop_front();
					if (trigger !== exp_r.trig)
						report_mismatch($sformatf("trigger %0b, expected %0b",
							trigger, exp_r.trig));
					if (busy_res !== exp_r.busy)
						report_mismatch($sformatf("busy_res %0b, expected %0b",
							busy_res, exp_r.busy));
					if (done_res !== exp_r.done)
						report_mismatch($sformatf("done_res %0b, expected %0b",
							done_res, exp_r.done));
					if (status !== exp_r.stat)
						report_mismatch($sformatf("status %0b, expected %0b",
							status, exp_r.stat));
					if (distance_cm !== exp_r.range_cm)
						report_mismatch($sformatf("distance_cm %0d, expected %0d",
							distance_cm, exp_r.range_cm));
				end
				seen++;
			end
			if (in_valid && !in_stall) begin
				exp_r = ranger_tick(start_req, echo);
				readings_q.push_back(exp_r);
				if (exp_r.done) begin
					if (exp_r.stat == STATUS_TIMEOUT)
						timeout_count++;
					else
						ok_count++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PRE_LOW: pre_len    = cfg_data[15:0];
					REG_PULSE:   pulse_len  = cfg_data[15:0];
					REG_TIMEOUT: wait_limit = cfg_data[23:0];
					REG_WIDE:    wide_count = cfg_data[0];
					default: ;
				endcase
			end
			pending = readings_q.size();
		end
	end

endmodule

[tb/tb.sv]
// Top of the echo ranger testbench: clock, reset, tick stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb;
	import uer_pkg::*;

	localparam int LIMIT_CYCLES = 20_000;
	localparam int HOLD_CYCLES  = 60;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  start_req = 1'b0;
	logic                  echo      = 1'b0;
	logic                  out_stall = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_PRE_LOW;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	wire                   in_stall;
	wire                   out_valid;
	wire                   trigger;
	wire                   busy_res;
	wire                   done_res;
	wire                   status;
	wire [15:0]            distance_cm;

	int bad_count;
	int pending;
	int ok_count;
	int timeout_count;

	int send_gap_pct   = 37;
	int recv_stall_pct = 76;
	bit hold_go        = 1'b0;
	int ticks_sent     = 0;
	int sequences      = 0;
	int cycles         = 0;

	// Settings currently loaded, used to shape the echo sequences.
	int cur_pre   = 40;
	int cur_pulse = 20;
	int cur_tmo   = 1000000;

	ultrasonic_echo_ranger dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_req   (start_req),
		.echo        (echo),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.trigger     (trigger),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.status      (status),
		.distance_cm (distance_cm),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	echo_ranger_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_req     (start_req),
		.echo          (echo),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.trigger       (trigger),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.status        (status),
		.distance_cm   (distance_cm),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.bad_count     (bad_count),
		.pending       (pending),
		.ok_count      (ok_count),
		.timeout_count (timeout_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycles, pending);
			$display("[ultrasonic_echo_ranger] ERROR");
			$finish;
		end
	end

	// Result side: random stalls, and one long hold-off on request so that the block backs up.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Offers one tick request and returns on the falling edge after it has been taken.
	task automatic send_tick(input logic want_start, input logic echo_level);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid  <= 1'b0;
			start_req <= 1'($urandom_range(1));
			echo      <= 1'($urandom_range(1));
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		start_req <= want_start;
		echo      <= echo_level;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Unused upper data bits are filled at random; the block must mask them.
	task automatic apply_setting(input logic [15:0] pre, input logic [15:0] pulse,
			input logic [23:0] tmo, input logic wide);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= REG_PRE_LOW;
		cfg_data  <= {8'($urandom_range(255)), pre};
		@(negedge clk);
		cfg_index <= REG_PULSE;
		cfg_data  <= {8'($urandom_range(255)), pulse};
		@(negedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= tmo;
		@(negedge clk);
		cfg_index <= REG_WIDE;
		cfg_data  <= {23'($urandom), wide};
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_pre   = int'(pre);
		cur_pulse = int'(pulse);
		cur_tmo   = int'(tmo);
	endtask

	// One measurement: start, trigger ticks, echo low for rise_wait ticks, high for high_len.
	// With lead set the echo is already high when the wait for the rising edge begins.
	task automatic measure(input bit lead, input int rise_wait, input int high_len);
		int i;
		int lim;
		bit ends_clean;
		lim = (cur_tmo == 0) ? 1 : cur_tmo;
		ends_clean = !lead && rise_wait < lim && high_len <= lim;
		send_tick(1'b1, lead);
		// Starts during the trigger phases must be ignored.
		for (i = 1; i < cur_pre + cur_pulse; i++)
			send_tick(1'($urandom_range(1)), lead);
		if (lead)
			repeat ($urandom_range(3, 1)) send_tick(1'b0, 1'b1);
		repeat (rise_wait) send_tick(1'b0, 1'b0);
		repeat (high_len) send_tick(1'b0, 1'b1);
		// A start on the finishing tick is ignored as well.
		send_tick(ends_clean ? 1'($urandom_range(1)) : 1'b0, 1'b0);
		send_tick(1'b0, 1'($urandom_range(1)));
		sequences++;
	endtask

	task automatic noise_burst(input int n);
		repeat (n) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic broken_start();
		send_tick(1'b1, 1'($urandom_range(1)));
		repeat ($urandom_range(cur_pre + cur_pulse + 3, 1))
			send_tick(1'b0, 1'($urandom_range(1)));
	endtask

	task automatic random_run(input int min_ticks, input int min_seq);
		int first_tick;
		int first_seq;
		int pick;
		int lim;
		int cap;
		int rise_w;
		int high_w;
		first_tick = ticks_sent;
		first_seq  = sequences;
		while (ticks_sent - first_tick < min_ticks || sequences - first_seq < min_seq) begin
			pick = $urandom_range(99);
			lim  = (cur_tmo == 0) ? 1 : cur_tmo;
			cap  = (lim > 130) ? 130 : lim;
			if (pick < 70) begin
				rise_w = ($urandom_range(7) == 0) ? $urandom_range(lim + 2)
					: $urandom_range(lim / 4 + 2);
				high_w = ($urandom_range(5) == 0) ? $urandom_range(lim + 3, 1)
					: $urandom_range(cap, 1);
				measure($urandom_range(9) == 0, rise_w, high_w);
			end else if (pick < 85)
				noise_burst($urandom_range(8, 1));
			else
				broken_start();
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles often, receiver stalls most of the time.
		measure(1'b0, 2, 59);
		apply_setting(16'd2, 16'd1, 24'd24, 1'b0);
		repeat (3) begin
			send_tick(1'b0, 1'b1);
			send_tick(1'b0, 1'b0);
		end
		measure(1'b0, 3, 20);
		measure(1'b1, 2, 5);
		measure(1'b0, 30, 3);
		measure(1'b0, 1, 30);
		apply_setting(16'd3, 16'd2, 24'd12, 1'b0);
		random_run(60, 5);

		// Roles swapped; zero pre-low, zero pulse and zero timeout first.
		send_gap_pct   = 76;
		recv_stall_pct = 37;
		apply_setting(16'd0, 16'd0, 24'd0, 1'b1);
		measure(1'b0, 0, 1);
		measure(1'b0, 1, 1);
		measure(1'b1, 0, 1);
		measure(1'b0, 0, 2);
		random_run(60, 6);

		// No idling at all, with one long hold-off on the result side.
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		apply_setting(16'($urandom_range(6)), 16'($urandom_range(5)), 24'd70,
			1'($urandom_range(1)));
		hold_go = 1'b1;
		random_run(120, 3);

		wait_drained();
		repeat (4) @(negedge clk);

		$display("Sent %0d tick requests in %0d echo sequences over five register settings,",
			ticks_sent, sequences);
		$display("with idling on either side, a long hold-off and 16- and 32-bit echo counts: ",
			"%0d ranges and %0d timeouts.", ok_count, timeout_count);
		if (bad_count == 0 && pending == 0)
			$display("[ultrasonic_echo_ranger] OK");
		else
			$display("[ultrasonic_echo_ranger] ERROR");
		$finish;
	end

endmodule

[sim.f]
src/uer_pkg.sv
src/ultrasonic_echo_ranger.sv
tb/echo_ranger_checker.sv
tb/tb.sv
